// ----- src/wba_pkg.sv -----
`default_nettype none

package wba_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int LOAD_W     = 32;
  localparam int SUM_W      = LOAD_W + 1;
  localparam int IDX_W      = $clog2(MAX_PROCS);
  localparam int CNT_W      = $clog2(MAX_PROCS + 1);
  localparam int TASK_W     = 16;
  localparam int COUNT_W    = 5;
  localparam int CHOSEN_W   = 4;
  localparam int MAXWL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_PROC_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET  = 5'd1;
  localparam logic               POLICY_RESET = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_MIN,
    ST_DECIDE,
    ST_SCAN_FIT,
    ST_COMMIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LOAD_W-1:0] wr_data;
    logic              clr;
  } mem_req_t;

  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen;
    logic [MAXWL_W-1:0]  max_load;
    logic                assigned;
    logic                batch_end;
  } result_t;

endpackage

`default_nettype wire

// ----- src/workload_balance_assigner.sv -----
// Each task takes one scan of the load memory in least-workload mode and up to
// two in best-workload mode, n being the processors in use (up to 16), then one
// write-back; a processor count of zero gives its result without a scan.
// Each scan covers the n entries, one read per cycle. Tasks are taken one at a time;
// the next task is accepted while the result waits in the output register.
// Reset clears all loads at once through per-entry valid bits and sets
// processor_count to 1 and policy_mode to 0.
`default_nettype none

module workload_balance_assigner (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [wba_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [wba_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire [wba_pkg::TASK_W-1:0]        task_time_i,
  input  wire                              last_task_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [wba_pkg::CHOSEN_W-1:0]     chosen_processor_o,
  output logic [wba_pkg::MAXWL_W-1:0]      max_workload_o,
  output logic                             assigned_o,
  output logic                             batch_end_o
);
  import wba_pkg::*;

  logic [COUNT_W-1:0] count_q;
  logic               mode_q;
  mem_req_t           mem_req;
  logic [LOAD_W-1:0]  rdata;
  logic               res_valid;
  logic               slot_free;
  result_t            res;
  result_t            out_q;
  logic               out_vld_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
      mode_q  <= POLICY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PROC_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_POLICY:     mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  wba_load_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  wba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .task_time_i (task_time_i),
    .last_task_i (last_task_i),
    .count_i     (count_q),
    .mode_i      (mode_q),
    .mem_req_o   (mem_req),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .slot_free_i (slot_free),
    .res_o       (res)
  );

  assign slot_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (slot_free) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign chosen_processor_o = out_q.chosen;
  assign max_workload_o     = out_q.max_load;
  assign assigned_o         = out_q.assigned;
  assign batch_end_o        = out_q.batch_end;

endmodule

`default_nettype wire

// ----- src/wba_load_mem.sv -----
`default_nettype none

module wba_load_mem (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wba_pkg::mem_req_t             req_i,
  output logic [wba_pkg::LOAD_W-1:0]    rdata_o
);
  import wba_pkg::*;

  // An entry whose valid bit is clear reads as zero, so a batch end or reset
  // empties every load at once.
  logic [LOAD_W-1:0]    mem_q [MAX_PROCS];
  logic [MAX_PROCS-1:0] vld_q;
  logic [LOAD_W-1:0]    rdata_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ----- src/wba_ctrl.sv -----
`default_nettype none

module wba_ctrl (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire [wba_pkg::TASK_W-1:0]     task_time_i,
  input  wire                           last_task_i,
  input  wire [wba_pkg::COUNT_W-1:0]    count_i,
  input  wire                           mode_i,
  output wba_pkg::mem_req_t             mem_req_o,
  input  wire [wba_pkg::LOAD_W-1:0]     rdata_i,
  output logic                          res_valid_o,
  input  wire                           slot_free_i,
  output wba_pkg::result_t              res_o
);
  import wba_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [TASK_W-1:0] task_q, task_d;
  logic              last_q, last_d;
  logic              mode_q, mode_d;
  logic              assigned_q, assigned_d;
  logic              found_q, found_d;
  logic [LOAD_W-1:0] min_q, min_d;
  logic [LOAD_W-1:0] max_q, max_d;
  logic [LOAD_W-1:0] pick_load_q, pick_load_d;
  logic [LOAD_W-1:0] new_load_q, new_load_d;
  logic [IDX_W-1:0]  lo_q, lo_d;
  logic [IDX_W-1:0]  pick_q, pick_d;

  logic [CNT_W-1:0]  n_clamp;
  logic [IDX_W-1:0]  cur_idx;
  logic [SUM_W-1:0]  fit_sum;
  logic [SUM_W-1:0]  lo_sum;
  logic [SUM_W-1:0]  commit_sum;
  logic [LOAD_W-1:0] sat_load;
  logic              fits;

  assign n_clamp    = (count_i > COUNT_W'(MAX_PROCS)) ? CNT_W'(MAX_PROCS) : CNT_W'(count_i);
  assign cur_idx    = IDX_W'(cnt_q - CNT_W'(1));
  assign fit_sum    = {1'b0, rdata_i} + SUM_W'(task_q);
  assign fits       = fit_sum <= {1'b0, max_q};
  assign lo_sum     = {1'b0, min_q} + SUM_W'(task_q);
  assign commit_sum = {1'b0, pick_load_q} + SUM_W'(task_q);
  assign sat_load   = commit_sum[LOAD_W] ? '1 : commit_sum[LOAD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    n_q         <= n_d;
    task_q      <= task_d;
    last_q      <= last_d;
    mode_q      <= mode_d;
    assigned_q  <= assigned_d;
    found_q     <= found_d;
    min_q       <= min_d;
    max_q       <= max_d;
    pick_load_q <= pick_load_d;
    new_load_q  <= new_load_d;
    lo_q        <= lo_d;
    pick_q      <= pick_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    task_d      = task_q;
    last_d      = last_q;
    mode_d      = mode_q;
    assigned_d  = assigned_q;
    found_d     = found_q;
    min_d       = min_q;
    max_d       = max_q;
    pick_load_d = pick_load_q;
    new_load_d  = new_load_q;
    lo_d        = lo_q;
    pick_d      = pick_q;
    mem_req_o   = '0;
    res_valid_o = 1'b0;
    in_stall_o  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          task_d     = task_time_i;
          last_d     = last_task_i;
          mode_d     = mode_i;
          n_d        = n_clamp;
          cnt_d      = '0;
          pick_d     = '0;
          assigned_d = (n_clamp != '0);
          state_d    = (n_clamp != '0) ? ST_SCAN_MIN : ST_EMIT;
        end
      end
      ST_SCAN_MIN: begin
        mem_req_o.rd_en   = cnt_q < n_q;
        mem_req_o.rd_addr = cnt_q[IDX_W-1:0];
        cnt_d             = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          min_d = rdata_i;
          max_d = rdata_i;
          lo_d  = cur_idx;
        end else if (cnt_q != '0) begin
          if (rdata_i < min_q) begin
            min_d = rdata_i;
            lo_d  = cur_idx;
          end
          if (rdata_i > max_q) begin
            max_d = rdata_i;
          end
        end
        if (cnt_q == n_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        pick_d      = lo_q;
        pick_load_d = min_q;
        cnt_d       = '0;
        found_d     = 1'b0;
        if (mode_q && (lo_sum <= {1'b0, max_q})) begin
          state_d = ST_SCAN_FIT;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_SCAN_FIT: begin
        mem_req_o.rd_en   = cnt_q < n_q;
        mem_req_o.rd_addr = cnt_q[IDX_W-1:0];
        cnt_d             = cnt_q + CNT_W'(1);
        // The smallest gap under the peak is the largest load that still fits.
        if ((cnt_q != '0) && fits && (!found_q || (rdata_i > pick_load_q))) begin
          found_d     = 1'b1;
          pick_d      = cur_idx;
          pick_load_d = rdata_i;
        end
        if (cnt_q == n_q) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = pick_q;
        mem_req_o.wr_data = sat_load;
        new_load_d        = sat_load;
        state_d           = ST_EMIT;
      end
      ST_EMIT: begin
        res_valid_o = 1'b1;
        if (slot_free_i) begin
          mem_req_o.clr = last_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o           = '0;
    res_o.batch_end = last_q;
    res_o.assigned  = assigned_q;
    if (assigned_q) begin
      res_o.chosen   = CHOSEN_W'(pick_q);
      res_o.max_load = MAXWL_W'((new_load_q > max_q) ? new_load_q : max_q);
    end
  end

endmodule

`default_nettype wire

// ----- src/wba_checker.sv -----
`default_nettype none

module wba_checker (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  input  wire                              cfg_ready_o,
  input  wire [wba_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [wba_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire                              in_valid_i,
  input  wire                              in_stall_o,
  input  wire [wba_pkg::TASK_W-1:0]        task_time_i,
  input  wire                              last_task_i,
  input  wire                              out_valid_o,
  input  wire                              out_stall_i,
  input  wire [wba_pkg::CHOSEN_W-1:0]      chosen_processor_o,
  input  wire [wba_pkg::MAXWL_W-1:0]       max_workload_o,
  input  wire                              assigned_o,
  input  wire                              batch_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(chosen_processor_o)
      && $stable(max_workload_o) && $stable(assigned_o) && $stable(batch_end_o))
    else $error("stalled result beat changed");

  a_unassigned_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !assigned_o |-> chosen_processor_o == '0 && max_workload_o == '0)
    else $error("result without assignment carries nonzero fields");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while a task is in progress");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a task in progress");

endmodule

bind workload_balance_assigner wba_checker u_wba_checker (.*);

`default_nettype wire
